// ===== hw/rtl/i8mvp_pkg.sv =====
package i8mvp_pkg;

    // activation store depth and derived address width
    localparam int MAX_COLUMNS = 4096;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);

    // field and register widths
    localparam int ELEM_W     = 8;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 28;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 13;
    localparam int ROW_CNT_W  = 17;
    localparam int CFG_DATA_W = 17;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [COL_W-1:0]     MAX_COLS_C  = COL_W'(MAX_COLUMNS);
    localparam logic [COL_W-1:0]     ONE_COL_C   = COL_W'(1);
    localparam logic [ROW_CNT_W-1:0] MAX_ROWS_C  = ROW_CNT_W'(65536);
    localparam logic [ROW_CNT_W-1:0] ONE_ROW_C   = ROW_CNT_W'(1);
    localparam logic [COL_W-1:0]     COL_RESET_C = COL_W'(4096);
    localparam logic [ROW_CNT_W-1:0] ROW_RESET_C = ROW_CNT_W'(1);

    typedef enum logic {
        OP_ACT    = 1'b0,
        OP_WEIGHT = 1'b1
    } op_t;

    typedef enum logic {
        CFG_COLUMN_COUNT = 1'b0,
        CFG_ROW_COUNT    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t                      op;
        logic signed [ELEM_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_number;
        logic                    last_row;
    } out_word_t;

    // row bookkeeping that travels with a weight through the mac pipeline
    typedef struct packed {
        logic             row_end;
        logic [ROW_W-1:0] row_number;
        logic             last_row;
    } tag_t;

endpackage

// ===== hw/rtl/int8_matrix_vector_product.sv =====
// int8 matrix-vector product. Each input word is either an activation
// (op = 0), stored in order into a 4096 x 8 activation ram, or a weight
// (op = 1), multiplied by the stored activation at the current column and
// added into a 28-bit signed accumulator; after column_count weights the row
// sum leaves with its row number and a last-row flag, and the accumulator
// clears. One input word is taken per clock while in_stall is low, with
// activations and weights mixed freely; a weight waits in stage a for the
// registered ram read, the product is registered in stage b, and the row
// sum is pushed on from there. Results wait in an 8-entry queue; every
// weight that ends a row books a queue slot when taken, and in_stall rises
// only while all eight slots are booked, i.e. when the output side has held
// off long enough. in_stall comes from a register, with no path from
// out_stall. The activation ram has no reset: load the vector before the
// first weight row. Write column_count and row_count only while idle.
module int8_matrix_vector_product (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  i8mvp_pkg::in_word_t                      in_data,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output i8mvp_pkg::out_word_t                     out_data,
    input  logic                                     cfg_write,
    input  i8mvp_pkg::cfg_index_t                    cfg_index,
    input  logic [i8mvp_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // configuration registers
    logic [i8mvp_pkg::COL_W-1:0]     column_count_reg;
    logic [i8mvp_pkg::ROW_CNT_W-1:0] row_count_reg;
    logic [i8mvp_pkg::COL_W-1:0]     eff_cols;
    logic [i8mvp_pkg::ROW_CNT_W-1:0] eff_rows;

    // positions and row counter
    logic [i8mvp_pkg::ADDR_W-1:0]    load_pos_reg;
    logic [i8mvp_pkg::ADDR_W-1:0]    load_pos_next;
    logic [i8mvp_pkg::ADDR_W-1:0]    column_pos_reg;
    logic [i8mvp_pkg::ADDR_W-1:0]    column_pos_next;
    logic [i8mvp_pkg::ROW_W-1:0]     row_counter_reg;
    logic [i8mvp_pkg::ROW_W-1:0]     row_counter_next;

    // output slots booked: queued results plus row ends still in the mac
    logic [i8mvp_pkg::FIFO_AW:0]     used_reg;
    logic [i8mvp_pkg::FIFO_AW:0]     used_next;

    logic                            in_accept;
    logic                            act_accept;
    logic                            weight_accept;
    logic                            load_wrap;
    logic                            col_end;
    logic                            last_row;
    logic                            out_pop;
    i8mvp_pkg::tag_t                 issue_tag;
    logic [i8mvp_pkg::ELEM_W-1:0]    act_rd_data;
    logic                            res_push;
    i8mvp_pkg::out_word_t            res_word;

    assign in_stall      = (used_reg == (i8mvp_pkg::FIFO_AW+1)'(i8mvp_pkg::FIFO_DEPTH));
    assign in_accept     = in_valid && !in_stall;
    assign act_accept    = in_accept && (in_data.op == i8mvp_pkg::OP_ACT);
    assign weight_accept = in_accept && (in_data.op == i8mvp_pkg::OP_WEIGHT);
    assign out_pop       = out_valid && !out_stall;

    // zero acts as one, anything above the store size saturates
    always_comb
    begin
        if (column_count_reg == '0)
        begin
            eff_cols = i8mvp_pkg::ONE_COL_C;
        end
        else if (column_count_reg > i8mvp_pkg::MAX_COLS_C)
        begin
            eff_cols = i8mvp_pkg::MAX_COLS_C;
        end
        else
        begin
            eff_cols = column_count_reg;
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            eff_rows = i8mvp_pkg::ONE_ROW_C;
        end
        else if (row_count_reg > i8mvp_pkg::MAX_ROWS_C)
        begin
            eff_rows = i8mvp_pkg::MAX_ROWS_C;
        end
        else
        begin
            eff_rows = row_count_reg;
        end
    end

    // "at or beyond" compares so a shrunk count mid-row still wraps
    assign load_wrap = (i8mvp_pkg::COL_W'(load_pos_reg) + i8mvp_pkg::ONE_COL_C) >= eff_cols;
    assign col_end   = (i8mvp_pkg::COL_W'(column_pos_reg) + i8mvp_pkg::ONE_COL_C) >= eff_cols;
    assign last_row  = (i8mvp_pkg::ROW_CNT_W'(row_counter_reg) + i8mvp_pkg::ONE_ROW_C)
                       >= eff_rows;

    always_comb
    begin
        load_pos_next    = load_pos_reg;
        column_pos_next  = column_pos_reg;
        row_counter_next = row_counter_reg;
        if (act_accept)
        begin
            load_pos_next = load_wrap ? '0 : load_pos_reg + 1'b1;
        end
        if (weight_accept)
        begin
            if (col_end)
            begin
                column_pos_next  = '0;
                row_counter_next = last_row ? '0 : row_counter_reg + 1'b1;
            end
            else
            begin
                column_pos_next = column_pos_reg + 1'b1;
            end
        end
    end

    // book a slot when a row-ending weight is taken, free it on pop
    always_comb
    begin
        used_next = used_reg;
        if ((weight_accept && col_end) && !out_pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (out_pop && !(weight_accept && col_end))
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= i8mvp_pkg::COL_RESET_C;
            row_count_reg    <= i8mvp_pkg::ROW_RESET_C;
            load_pos_reg     <= '0;
            column_pos_reg   <= '0;
            row_counter_reg  <= '0;
            used_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    i8mvp_pkg::CFG_COLUMN_COUNT:
                    begin
                        column_count_reg <= cfg_data[i8mvp_pkg::COL_W-1:0];
                    end
                    i8mvp_pkg::CFG_ROW_COUNT:
                    begin
                        row_count_reg <= cfg_data[i8mvp_pkg::ROW_CNT_W-1:0];
                    end
                endcase
            end
            load_pos_reg    <= load_pos_next;
            column_pos_reg  <= column_pos_next;
            row_counter_reg <= row_counter_next;
            used_reg        <= used_next;
        end
    end

    // activation store: written by activation words, read by weight words
    i8mvp_ram #(
        .WIDTH (i8mvp_pkg::ELEM_W),
        .DEPTH (i8mvp_pkg::MAX_COLUMNS)
    ) u_act_ram (
        .clk     (clk),
        .wr_en   (act_accept),
        .wr_addr (load_pos_reg),
        .wr_data (in_data.element_value),
        .rd_en   (weight_accept),
        .rd_addr (column_pos_reg),
        .rd_data (act_rd_data)
    );

    assign issue_tag.row_end    = col_end;
    assign issue_tag.row_number = row_counter_reg;
    assign issue_tag.last_row   = last_row;

    // multiply then accumulate, one weight per clock
    i8mvp_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (weight_accept),
        .issue_weight (in_data.element_value),
        .issue_tag    (issue_tag),
        .act_data     ($signed(act_rd_data)),
        .res_push     (res_push),
        .res_word     (res_word)
    );

    // result queue in front of the output channel
    i8mvp_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_word  (res_word),
        .pop        (out_pop),
        .head_valid (out_valid),
        .head_word  (out_data)
    );

    // booked slots never exceed the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (i8mvp_pkg::FIFO_AW+1)'(i8mvp_pkg::FIFO_DEPTH))
        else $error("output slot booking exceeds queue depth");

    // a queued word always holds a booked slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_reg != '0))
        else $error("queued word without a booked slot");

    // a row-ending weight yields its row sum once it has passed stages a and b
    assert property (@(posedge clk) disable iff (!rst_n)
        (weight_accept && col_end) |=> ##1 res_push)
        else $error("row end did not produce a result");

endmodule

// ===== hw/rtl/i8mvp_ram.sv =====
module i8mvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/i8mvp_mac.sv =====
module i8mvp_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // weight issued in the same cycle as the activation read
    input  logic                                   issue_valid,
    input  logic signed [i8mvp_pkg::ELEM_W-1:0]    issue_weight,
    input  i8mvp_pkg::tag_t                        issue_tag,
    // activation from the store, registered by the ram in the cycle after issue
    input  logic signed [i8mvp_pkg::ELEM_W-1:0]    act_data,
    output logic                                   res_push,
    output i8mvp_pkg::out_word_t                   res_word
);

    // stage a: weight waits for the activation read
    logic                                   a_valid_reg;
    logic signed [i8mvp_pkg::ELEM_W-1:0]    a_weight_reg;
    i8mvp_pkg::tag_t                        a_tag_reg;

    // stage b: registered product
    logic                                   b_valid_reg;
    logic signed [i8mvp_pkg::PROD_W-1:0]    b_prod_reg;
    i8mvp_pkg::tag_t                        b_tag_reg;

    logic signed [i8mvp_pkg::PROD_W-1:0]    prod;
    logic signed [i8mvp_pkg::ACC_W-1:0]     acc_reg;
    logic signed [i8mvp_pkg::ACC_W-1:0]     acc_next;
    logic signed [i8mvp_pkg::ACC_W-1:0]     acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= issue_valid;
            b_valid_reg <= a_valid_reg;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_weight_reg <= issue_weight;
        a_tag_reg    <= issue_tag;
        b_prod_reg   <= prod;
        b_tag_reg    <= a_tag_reg;
    end

    assign prod = a_weight_reg * act_data;

    // sum wraps at accumulator width
    assign acc_sum = acc_reg
        + {{(i8mvp_pkg::ACC_W - i8mvp_pkg::PROD_W){b_prod_reg[i8mvp_pkg::PROD_W-1]}},
           b_prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (b_valid_reg)
        begin
            acc_next = b_tag_reg.row_end ? '0 : acc_sum;
        end
    end

    assign res_push            = b_valid_reg && b_tag_reg.row_end;
    assign res_word.row_sum    = acc_sum;
    assign res_word.row_number = b_tag_reg.row_number;
    assign res_word.last_row   = b_tag_reg.last_row;

endmodule

// ===== hw/rtl/i8mvp_fifo.sv =====
module i8mvp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i8mvp_pkg::out_word_t push_word,
    input  logic                 pop,
    output logic                 head_valid,
    output i8mvp_pkg::out_word_t head_word
);

    i8mvp_pkg::out_word_t              entry [i8mvp_pkg::FIFO_DEPTH];
    logic [i8mvp_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [i8mvp_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [i8mvp_pkg::FIFO_AW:0]       count_reg;
    logic [i8mvp_pkg::FIFO_AW:0]       count_next;

    // space is reserved upstream, so a push never finds the queue full
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_word;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_word  = entry[rd_ptr_reg];

endmodule

// ===== verif/mvp_row_checker.sv =====
`timescale 1ns / 100ps

// watches both channels and the register port, tracks the block's state,
// predicts every row result and compares it with what leaves the block
module mvp_row_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  i8mvp_pkg::in_word_t              in_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  i8mvp_pkg::out_word_t             out_data,
    input  logic                             cfg_write,
    input  i8mvp_pkg::cfg_index_t            cfg_index,
    input  logic [i8mvp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               errors,
    output int                               pending,
    output int                               rows_checked
);

    logic signed [i8mvp_pkg::ELEM_W-1:0] act_mem [i8mvp_pkg::MAX_COLUMNS];
    int                                  load_pos;
    int                                  col_pos;
    logic [i8mvp_pkg::ACC_W-1:0]         row_acc;
    int                                  row_idx;
    logic [i8mvp_pkg::COL_W-1:0]         col_cfg;
    logic [i8mvp_pkg::ROW_CNT_W-1:0]     row_cfg;
    i8mvp_pkg::out_word_t                row_words_due [$];
    int                                  err_cnt;
    int                                  seen_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        i8mvp_pkg::in_word_t  w;
        i8mvp_pkg::out_word_t want;
        i8mvp_pkg::out_word_t got;
        int                   prod;
        int                   ncol;
        int                   nrow;
        bit                   is_last;

        if (!rst_n)
        begin
            load_pos = 0;
            col_pos  = 0;
            row_acc  = '0;
            row_idx  = 0;
            col_cfg  = i8mvp_pkg::COL_RESET_C;
            row_cfg  = i8mvp_pkg::ROW_RESET_C;
            err_cnt  = 0;
            seen_cnt = 0;
            row_words_due.delete();
            pending      <= 0;
            errors       <= 0;
            rows_checked <= 0;
        end
        else
        begin
            // result side first: a row word never leaves in the cycle its weight enters
            if (out_valid && !out_stall)
            begin
                got = out_data;
                seen_cnt++;
                if (row_words_due.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected row word: sum %0d row %0d last %0b",
                                 got.row_sum, got.row_number, got.last_row);
                end
                else
                begin
                    want = row_words_due.pop_front();
                    if (got.row_sum !== want.row_sum || got.row_number !== want.row_number
                        || got.last_row !== want.last_row)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"row word mismatch: expected sum %0d row %0d last %0b,",
                                      " got sum %0d row %0d last %0b"},
                                     want.row_sum, want.row_number, want.last_row,
                                     got.row_sum, got.row_number, got.last_row);
                    end
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    i8mvp_pkg::CFG_COLUMN_COUNT: col_cfg = cfg_data[i8mvp_pkg::COL_W-1:0];
                    i8mvp_pkg::CFG_ROW_COUNT:    row_cfg = cfg_data[i8mvp_pkg::ROW_CNT_W-1:0];
                    default:                     ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                w    = in_data;
                // zero columns act as one, oversize saturates at the store depth
                ncol = (col_cfg == 0) ? 1
                     : (col_cfg > i8mvp_pkg::MAX_COLUMNS) ? i8mvp_pkg::MAX_COLUMNS
                     : int'(col_cfg);
                if (w.op == i8mvp_pkg::OP_ACT)
                begin
                    if (load_pos < i8mvp_pkg::MAX_COLUMNS)
                        act_mem[load_pos] = w.element_value;
                    load_pos = (load_pos + 1 >= ncol) ? 0 : load_pos + 1;
                end
                else
                begin
                    prod    = int'(w.element_value) * int'(act_mem[col_pos]);
                    row_acc = row_acc + i8mvp_pkg::ACC_W'(prod);
                    // a shrunk column count ends the row at once
                    if (col_pos + 1 < ncol)
                        col_pos++;
                    else
                    begin
                        nrow    = (row_cfg == 0) ? 1 : (row_cfg > 65536) ? 65536 : int'(row_cfg);
                        is_last = (row_idx + 1 >= nrow);
                        want.row_sum    = signed'(row_acc);
                        want.row_number = i8mvp_pkg::ROW_W'(row_idx);
                        want.last_row   = is_last;
                        row_words_due.push_back(want);
                        col_pos = 0;
                        row_acc = '0;
                        row_idx = is_last ? 0 : ((row_idx + 1) & 16'hFFFF);
                    end
                end
            end

            pending      <= row_words_due.size();
            errors       <= err_cnt;
            rows_checked <= seen_cnt;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// stimulus and verdict for the int8 matrix-vector product; all checking
// lives in the row checker next to the block
module tb_top;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    i8mvp_pkg::in_word_t              in_data   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    i8mvp_pkg::out_word_t             out_data;
    logic                             cfg_write = 1'b0;
    i8mvp_pkg::cfg_index_t            cfg_index = i8mvp_pkg::CFG_COLUMN_COUNT;
    logic [i8mvp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int rows_checked;

    // stimulus-side view of the block's positions, used to keep weights away
    // from activation entries that were never loaded and to find row ends
    bit loaded [i8mvp_pkg::MAX_COLUMNS];
    int ld_pos     = 0;
    int col_pos    = 0;
    int ncols      = i8mvp_pkg::MAX_COLUMNS;

    int words_sent = 0;
    int rand_words = 0;
    int reg_writes = 0;
    int burst_left = 0;

    // long receiver hold-off, requested once by the stimulus
    bit hold_now  = 1'b0;
    bit hold_done = 1'b0;

    int8_matrix_vector_product dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mvp_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .rows_checked (rows_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit far beyond the slowest legal run
    initial
    begin
        #(20_000_000);
        $display("int8_matrix_vector_product: mismatch");
        $finish;
    end

    // result side: short stalls, stall-free stretches, the odd long stall,
    // and one very long hold-off so the result queue fills and the block
    // pushes back on its input
    initial
    begin
        int r;
        int n;
        bit v;

        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_now && !hold_done)
            begin
                v         = 1'b1;
                n         = 250;
                hold_done = 1'b1;
            end
            else if (r < 50)
            begin
                v = 1'b0;
                n = $urandom_range(1, 8);
            end
            else if (r < 85)
            begin
                v = 1'b1;
                n = $urandom_range(1, 3);
            end
            else if (r < 95)
            begin
                v = 1'b0;
                n = $urandom_range(20, 80);
            end
            else
            begin
                v = 1'b1;
                n = $urandom_range(10, 40);
            end
            out_stall <= v;
            // a hold-off request cuts the current stretch short
            repeat (n)
            begin
                @(posedge clk);
                if (hold_now && !hold_done)
                    break;
            end
        end
    end

    // element value with the extremes weighted up
    function automatic logic signed [i8mvp_pkg::ELEM_W-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return -8'sd128;
        if (r < 16)
            return 8'sd127;
        if (r < 20)
            return '0;
        return i8mvp_pkg::ELEM_W'($urandom_range(0, 255));
    endfunction

    // offer one word after a random gap and hold it until taken
    task automatic send_word(i8mvp_pkg::op_t op, logic signed [i8mvp_pkg::ELEM_W-1:0] v);
        int r;
        int gap;

        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (r < 3)
        begin
            burst_left = $urandom_range(50, 200);
            gap        = 0;
        end
        else if (r < 70)
            gap = 0;
        else if (r < 96)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);

        // never let a weight read an entry that was never loaded
        if (op == i8mvp_pkg::OP_WEIGHT && !loaded[col_pos])
            op = i8mvp_pkg::OP_ACT;

        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, element_value: v};
        do
            @(posedge clk);
        while (in_stall);

        if (op == i8mvp_pkg::OP_ACT)
        begin
            if (ld_pos < i8mvp_pkg::MAX_COLUMNS)
                loaded[ld_pos] = 1'b1;
            ld_pos = (ld_pos + 1 >= ncols) ? 0 : ld_pos + 1;
        end
        else
            col_pos = (col_pos + 1 >= ncols) ? 0 : col_pos + 1;
        words_sent++;
    endtask

    // register write once every expected row word is out and the pipe has drained
    task automatic set_reg(i8mvp_pkg::cfg_index_t idx, int val);
        int c;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= i8mvp_pkg::CFG_DATA_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
        if (idx == i8mvp_pkg::CFG_COLUMN_COUNT)
        begin
            c     = val & 32'h1FFF;
            ncols = (c == 0) ? 1 : (c > i8mvp_pkg::MAX_COLUMNS) ? i8mvp_pkg::MAX_COLUMNS : c;
        end
    endtask

    // realign the load position, then write a whole vector
    task automatic load_full(bit fixed, logic signed [i8mvp_pkg::ELEM_W-1:0] v);
        while (ld_pos != 0)
            send_word(i8mvp_pkg::OP_ACT, fixed ? v : pick_elem());
        repeat (ncols) send_word(i8mvp_pkg::OP_ACT, fixed ? v : pick_elem());
    endtask

    // weights until the column position wraps, i.e. one row finished
    task automatic send_row(bit fixed, logic signed [i8mvp_pkg::ELEM_W-1:0] v);
        do
            send_word(i8mvp_pkg::OP_WEIGHT, fixed ? v : pick_elem());
        while (col_pos != 0);
    endtask

    initial
    begin
        int  c;
        int  rows_todo;
        int  acts_todo;
        int  base;
        int  p;
        bit  first;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---

        // three columns, two rows: extremes of both operands
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 3);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 2);
        send_word(i8mvp_pkg::OP_ACT, -8'sd128);
        send_word(i8mvp_pkg::OP_ACT, 8'sd127);
        send_word(i8mvp_pkg::OP_ACT, -8'sd1);
        send_word(i8mvp_pkg::OP_WEIGHT, -8'sd128);
        send_word(i8mvp_pkg::OP_WEIGHT, -8'sd128);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd127);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd127);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd127);
        send_word(i8mvp_pkg::OP_WEIGHT, -8'sd1);

        // column count shrunk in the middle of a row: the next weight closes it
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 5);
        load_full(1'b0, '0);
        repeat (3) send_word(i8mvp_pkg::OP_WEIGHT, pick_elem());
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 2);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd127);

        // zero column and row counts behave as one
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 0);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 0);
        send_word(i8mvp_pkg::OP_ACT, 8'sd85);
        send_word(i8mvp_pkg::OP_WEIGHT, -8'sd86);

        // row count lowered in the middle of a pass: next row is the last
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 1);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 4);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd3);
        send_word(i8mvp_pkg::OP_WEIGHT, -8'sd7);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 2);
        send_word(i8mvp_pkg::OP_WEIGHT, 8'sd100);

        // 64-column rows: large positive and large negative sums
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 64);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 65536);
        load_full(1'b1, -8'sd128);
        send_row(1'b1, -8'sd128);
        send_row(1'b1, 8'sd127);

        // oversize counts saturate: no wrap at the low bits, then a shrink
        // to one column closes the load and the row at once
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 8191);
        set_reg(i8mvp_pkg::CFG_ROW_COUNT, 131071);
        repeat (3) send_word(i8mvp_pkg::OP_ACT, pick_elem());
        repeat (5) send_word(i8mvp_pkg::OP_WEIGHT, pick_elem());
        set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, 1);
        send_word(i8mvp_pkg::OP_ACT, pick_elem());
        send_word(i8mvp_pkg::OP_WEIGHT, pick_elem());

        // --- random phases: whole vectors and rows with random content,
        // plus stray words; the first one runs under the long hold-off ---
        first = 1'b1;
        while (words_sent < 1100)
        begin
            if (first)
            begin
                c         = 1;
                p         = 3;
                rows_todo = 40;
                acts_todo = 5;
            end
            else
            begin
                c         = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                                       : $urandom_range(17, 64);
                p         = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                       : $urandom_range(9, 300);
                rows_todo = $urandom_range(2, 20);
                acts_todo = c * $urandom_range(0, 2);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, c);
                set_reg(i8mvp_pkg::CFG_ROW_COUNT, p);
            end
            else
            begin
                set_reg(i8mvp_pkg::CFG_ROW_COUNT, p);
                set_reg(i8mvp_pkg::CFG_COLUMN_COUNT, c);
            end

            base = words_sent;
            load_full(1'b0, '0);
            if (first)
                hold_now = 1'b1;
            first = 1'b0;

            while ((rows_todo > 0 || acts_todo > 0) && words_sent < 1100)
            begin
                if ($urandom_range(0, 19) == 0)
                    // stray word of either kind
                    send_word(i8mvp_pkg::op_t'($urandom_range(0, 1)), pick_elem());
                else if (acts_todo > 0 && (rows_todo == 0 || $urandom_range(0, 3) == 0))
                begin
                    // vector reload interleaved with the weight stream
                    send_word(i8mvp_pkg::OP_ACT, pick_elem());
                    acts_todo--;
                end
                else
                begin
                    send_word(i8mvp_pkg::OP_WEIGHT, pick_elem());
                    if (col_pos == 0)
                        rows_todo--;
                end
            end
            rand_words += words_sent - base;
        end

        // drain: every expected row word out, then a few spare cycles
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d input words (%0d in random phases) and %0d register writes",
                 words_sent, rand_words, reg_writes);
        $display("%0d row words compared, %0d failures", rows_checked, errors);
        if (errors == 0 && pending == 0)
            $display("int8_matrix_vector_product: match");
        else
            $display("int8_matrix_vector_product: mismatch");
        $finish;
    end

endmodule
